[rtl/core/lsps_pkg.sv]
// Shared types, constants and helpers for the line-sensor PI steering core.
// Depends on nothing; used by lsps_div and line_sensor_pi_steering_core.
`timescale 1ns / 1ps

package lsps_pkg;

    // Field widths
    localparam int SENSOR_W  = 7;
    localparam int ERR_W     = 5;
    localparam int GAIN_W    = 8;
    localparam int SCALE_W   = 16;
    localparam int PWM_W     = 8;
    localparam int IN_DATA_W = 8;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_IDX_W = 2;

    // Error window
    localparam int WINDOW_LEN = 10;
    localparam int ERR_MAX    = 14;
    localparam int WSUM_W     = $clog2(ERR_MAX * WINDOW_LEN + 1) + 1;

    // Drive magnitude bound: |err*kp + wsum*ki| <= 14*255*(N+1)
    localparam int GAIN_MAX   = (1 << GAIN_W) - 1;
    localparam int DRIVE_MAX  = ERR_MAX * GAIN_MAX * (WINDOW_LEN + 1);
    localparam int MAG_W      = $clog2(DRIVE_MAX + 1);
    localparam int ACC_W      = MAG_W + 1;

    // Displacement = |drive| * 60 / full_scale; 60 is applied as 64 - 4
    localparam int DISP_SCALE = 60;
    localparam int DIVIDEND_W = $clog2(DRIVE_MAX * DISP_SCALE + 1);
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);
    localparam int MAC_CNT_W  = $clog2(GAIN_W);

    // PWM mapping
    localparam int PWM_CENTER = 196;
    localparam int PWM_MAX    = 255;

    // Reset values of the registers
    localparam logic [GAIN_W-1:0]  PROP_GAIN_RST  = GAIN_W'(50);
    localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST = GAIN_W'(2);
    localparam logic [SCALE_W-1:0] FULL_SCALE_RST = SCALE_W'(720);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN  = 2'd0,
        CFG_INTEG_GAIN = 2'd1,
        CFG_FULL_SCALE = 2'd2
    } lsps_cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_START,
        ST_DIV,
        ST_DONE
    } lsps_state_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [SCALE_W-1:0]    divisor;
    } lsps_div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } lsps_div_rsp_t;

    // Weighted position error; center sensor (bit 3) does not count.
    function automatic logic signed [ERR_W-1:0] sensor_error(
        input logic [SENSOR_W-1:0] bits
    );
        logic signed [ERR_W-1:0] e;
        e = '0;
        if (bits[6]) e = e - ERR_W'(9);
        if (bits[5]) e = e - ERR_W'(4);
        if (bits[4]) e = e - ERR_W'(1);
        if (bits[2]) e = e + ERR_W'(1);
        if (bits[1]) e = e + ERR_W'(4);
        if (bits[0]) e = e + ERR_W'(9);
        return e;
    endfunction

endpackage

[rtl/core/lsps_div.sv]
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on lsps_pkg (widths, request/response structs).
`timescale 1ns / 1ps

module lsps_div
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lsps_pkg::lsps_div_req_t req,
    output lsps_pkg::lsps_div_rsp_t rsp
);

    localparam int DW = lsps_pkg::DIVIDEND_W;
    localparam int SW = lsps_pkg::SCALE_W;
    localparam int CW = lsps_pkg::DIV_CNT_W;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [SW-1:0] rem_reg, rem_next;
    logic [SW-1:0] den_reg, den_next;
    logic [SW:0]   trial;
    logic          fits;

    // shift in next dividend bit, try subtract
    assign trial = {rem_reg, quo_reg[DW-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
            quo_next  = req.dividend;
            rem_next  = '0;
            // zero full scale acts as one
            den_next  = (req.divisor == '0) ? SW'(1) : req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? SW'(trial - {1'b0, den_reg}) : trial[SW-1:0];
            quo_next = {quo_reg[DW-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[rtl/core/line_sensor_pi_steering_core.sv]
// Top level of the line-sensor PI steering core: stream ports, registers,
// error window, bit-serial MAC and PWM mapping. Depends on lsps_pkg, lsps_div.
`timescale 1ns / 1ps

// Channel  Handshake            Payload
// -------  -------------------  ---------------------------------------------
// s_       s_tvalid / s_tready  s_tdata[6:0] sensor_bits, [7] zero
// m_       m_tvalid / m_tready  m_tdata[7:0] pwm_value, [12:8] position_error
// cfg_     cfg_valid/cfg_ready  cfg_index register index, cfg_data value
//
// The error window updates at the accept edge. From there to m_tvalid the word
// goes through bit-serial multiply-accumulate (one gain bit per cycle), a
// start state that launches the divide, the restoring divider (one quotient
// bit per cycle), the divider's registered done flag, and the output load.
// One word is in flight at a time: no new word is taken until the result
// of the last one has left the done phase.
// The next is taken once the result sits in the output register, even if
// m_tready is low; a full output register holds the result in the done phase.
// Reset (rst_n, async low) clears the error window, window sum and registers
// to their defaults. cfg_ready is always high.

module line_sensor_pi_steering_core
(
    input  logic        clk,
    input  logic        rst_n,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [6:0] sensor_bits
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // [7:0] pwm_value, [12:8] position_error
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int EW  = lsps_pkg::ERR_W;
    localparam int WW  = lsps_pkg::WSUM_W;
    localparam int GW  = lsps_pkg::GAIN_W;
    localparam int AW  = lsps_pkg::ACC_W;
    localparam int MW  = lsps_pkg::MAG_W;
    localparam int DW  = lsps_pkg::DIVIDEND_W;
    localparam int PW  = lsps_pkg::PWM_W;
    localparam int SW  = lsps_pkg::SCALE_W;
    localparam int MCW = lsps_pkg::MAC_CNT_W;
    localparam int N   = lsps_pkg::WINDOW_LEN;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [GW-1:0] prop_gain_reg;
    logic [GW-1:0] integ_gain_reg;
    logic [SW-1:0] full_scale_reg;
    logic          cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= lsps_pkg::PROP_GAIN_RST;
            integ_gain_reg <= lsps_pkg::INTEG_GAIN_RST;
            full_scale_reg <= lsps_pkg::FULL_SCALE_RST;
        end
        else if (cfg_we)
        begin
            case (lsps_pkg::lsps_cfg_idx_t'(cfg_index))
                lsps_pkg::CFG_PROP_GAIN:  prop_gain_reg  <= cfg_data[GW-1:0];
                lsps_pkg::CFG_INTEG_GAIN: integ_gain_reg <= cfg_data[GW-1:0];
                lsps_pkg::CFG_FULL_SCALE: full_scale_reg <= cfg_data[SW-1:0];
                default:                  ; // unmapped index, dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Control FSM
    // ---------------------------------------------------------------
    lsps_pkg::lsps_state_t state_reg, state_next;
    logic [MCW-1:0]        mac_cnt_reg, mac_cnt_next;
    logic                  out_free;
    logic                  s_accept;
    logic                  mac_run;
    logic                  out_load;
    logic                  div_start;
    lsps_pkg::lsps_div_req_t div_req;
    lsps_pkg::lsps_div_rsp_t div_rsp;

    assign out_free = !m_tvalid || m_tready;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lsps_pkg::ST_IDLE:
                if (s_tvalid) state_next = lsps_pkg::ST_MAC;
            lsps_pkg::ST_MAC:
                if (mac_cnt_reg == MCW'(GW - 1)) state_next = lsps_pkg::ST_START;
            lsps_pkg::ST_START:
                state_next = lsps_pkg::ST_DIV;
            lsps_pkg::ST_DIV:
                if (div_rsp.done) state_next = lsps_pkg::ST_DONE;
            lsps_pkg::ST_DONE:
                if (out_free) state_next = lsps_pkg::ST_IDLE;
            default:
                state_next = lsps_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        mac_run   = 1'b0;
        out_load  = 1'b0;
        div_start = 1'b0;
        case (state_reg)
            lsps_pkg::ST_IDLE:  s_tready  = 1'b1;
            lsps_pkg::ST_MAC:   mac_run   = 1'b1;
            lsps_pkg::ST_START: div_start = 1'b1;
            lsps_pkg::ST_DONE:  out_load  = out_free;
            default:            ;
        endcase
    end

    assign mac_cnt_next = mac_run ? mac_cnt_reg + MCW'(1) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= lsps_pkg::ST_IDLE;
            mac_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            mac_cnt_reg <= mac_cnt_next;
        end
    end

    // ---------------------------------------------------------------
    // Error and window. Sum tracked as running total: add newest,
    // drop the one falling off the end.
    // ---------------------------------------------------------------
    logic signed [EW-1:0] err_in;
    logic signed [EW-1:0] err_reg;
    logic signed [EW-1:0] hist_reg [N];
    logic signed [WW-1:0] wsum_reg, wsum_next;

    assign err_in    = lsps_pkg::sensor_error(s_tdata[lsps_pkg::SENSOR_W-1:0]);
    assign wsum_next = wsum_reg + WW'(err_in) - WW'(hist_reg[N-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
                hist_reg[i] <= '0;
            wsum_reg <= '0;
        end
        else if (s_accept)
        begin
            hist_reg[0] <= err_in;
            for (int i = 1; i < N; i++)
                hist_reg[i] <= hist_reg[i-1];
            wsum_reg <= wsum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
            err_reg <= err_in;
    end

    // ---------------------------------------------------------------
    // Bit-serial MAC: gains scanned MSB first,
    // acc = 2*acc + kp_bit*err + ki_bit*wsum
    // ---------------------------------------------------------------
    logic [GW-1:0]        kp_sh_reg, ki_sh_reg;
    logic signed [AW-1:0] acc_reg, acc_next;

    always_comb
    begin
        acc_next = acc_reg <<< 1;
        if (kp_sh_reg[GW-1]) acc_next = acc_next + AW'(err_reg);
        if (ki_sh_reg[GW-1]) acc_next = acc_next + AW'(wsum_reg);
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            kp_sh_reg <= prop_gain_reg;
            ki_sh_reg <= integ_gain_reg;
            acc_reg   <= '0;
        end
        else if (mac_run)
        begin
            kp_sh_reg <= {kp_sh_reg[GW-2:0], 1'b0};
            ki_sh_reg <= {ki_sh_reg[GW-2:0], 1'b0};
            acc_reg   <= acc_next;
        end
    end

    // ---------------------------------------------------------------
    // Scale by 60 (= 64 - 4) and divide by full scale
    // ---------------------------------------------------------------
    logic          drive_neg;
    logic [AW-1:0] drive_abs;
    logic [DW-1:0] mag_ext;
    logic [DW-1:0] div_dividend;
    logic          neg_reg;

    assign drive_neg = acc_reg[AW-1];
    assign drive_abs = drive_neg ? AW'(-acc_reg) : AW'(acc_reg);
    assign mag_ext   = DW'(drive_abs[MW-1:0]);

    assign div_dividend = (mag_ext << 6) - (mag_ext << 2);
    assign div_req      = {div_start, div_dividend, full_scale_reg};

    always_ff @(posedge clk)
    begin
        if (div_start)
            neg_reg <= drive_neg;
    end

    lsps_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ---------------------------------------------------------------
    // PWM = 196 - displacement, clamped to 0..255
    // ---------------------------------------------------------------
    logic [DW-1:0] q;
    logic [PW-1:0] pwm;

    assign q = div_rsp.quotient;

    always_comb
    begin
        if (neg_reg)
        begin
            if (q > DW'(lsps_pkg::PWM_MAX - lsps_pkg::PWM_CENTER))
                pwm = PW'(lsps_pkg::PWM_MAX);
            else
                pwm = PW'(lsps_pkg::PWM_CENTER) + q[PW-1:0];
        end
        else
        begin
            if (q > DW'(lsps_pkg::PWM_CENTER))
                pwm = '0;
            else
                pwm = PW'(lsps_pkg::PWM_CENTER) - q[PW-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic                 m_valid_reg;
    logic [PW-1:0]        pwm_reg;
    logic signed [EW-1:0] err_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (out_load)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pwm_reg     <= pwm;
            err_out_reg <= err_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, err_out_reg, pwm_reg};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == lsps_pkg::ST_DIV)
        else $error("divider finished outside divide phase");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> !s_tready)
        else $error("second word taken while one is in flight");

    a_wsum_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wsum_reg <= WW'(lsps_pkg::ERR_MAX * N)) &&
        (wsum_reg >= -WW'(lsps_pkg::ERR_MAX * N)))
        else $error("window sum out of range");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == lsps_pkg::ST_DONE))
        else $error("result posted outside done phase");

endmodule

[tb/tb_line_sensor_pi_steering_core.sv]
// Self-checking bench for line_sensor_pi_steering_core: directed and random sensor
// words under several gain settings, checked against an in-bench PI predictor.
// Depends on lsps_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_line_sensor_pi_steering_core;

    // A quiet stretch this long means the core is hung.
    localparam int STALL_LIMIT = 2000;
    // Cycles allowed after the last result for stray words to show up.
    localparam int DRAIN_CYCLES = 40;
    // Index with no register behind it; a write there must change nothing.
    localparam logic [lsps_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam int REPORT_CAP = 40;

    typedef struct packed {
        logic [lsps_pkg::PWM_W-1:0]        pwm;
        logic signed [lsps_pkg::ERR_W-1:0] err;
    } steer_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // Words waiting to go out, and results the core still owes us.
    logic [lsps_pkg::SENSOR_W-1:0] sensor_backlog [$];
    steer_word_t                   steer_expect [$];

    // Predictor copy of the core's registers and error window.
    logic [lsps_pkg::GAIN_W-1:0]  kp_model    = lsps_pkg::PROP_GAIN_RST;
    logic [lsps_pkg::GAIN_W-1:0]  ki_model    = lsps_pkg::INTEG_GAIN_RST;
    logic [lsps_pkg::SCALE_W-1:0] scale_model = lsps_pkg::FULL_SCALE_RST;
    int                           err_window [lsps_pkg::WINDOW_LEN];

    int unsigned fail_count;
    int unsigned words_sent;
    int unsigned words_checked;
    int unsigned pinned_high;
    int unsigned pinned_low;
    int unsigned phase_count;
    int unsigned idle_cycles;

    // Idle draws for both sides; *_calm > 0 means a run of back-to-back words.
    int unsigned send_gap;
    int unsigned send_calm;
    int unsigned send_draw;
    int unsigned recv_gap;
    int unsigned recv_calm;
    int unsigned recv_draw;

    line_sensor_pi_steering_core uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // [6:0] sensor_bits, [7] zero
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // [7:0] pwm_value, [12:8] position_error
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Signed weight per sensor bit, outer right first; the center counts zero.
    function automatic int line_offset(input logic [lsps_pkg::SENSOR_W-1:0] bits);
        int weight [lsps_pkg::SENSOR_W];
        int sum;
        weight = '{9, 4, 1, 0, -1, -4, -9};
        sum = 0;
        for (int k = 0; k < lsps_pkg::SENSOR_W; k++)
        begin
            if (bits[k])
                sum += weight[k];
        end
        return sum;
    endfunction

    // Shift the new error into the window, form the PI drive, scale it to PWM
    // steps (truncated toward zero) and clamp around the center command.
    task automatic predict_steering(input logic [lsps_pkg::SENSOR_W-1:0] bits);
        int          offset;
        int          wsum;
        longint      drive;
        longint      mag;
        longint      den;
        longint      disp;
        longint      pwm;
        steer_word_t word;
        offset = line_offset(bits);
        for (int i = lsps_pkg::WINDOW_LEN - 1; i > 0; i--)
            err_window[i] = err_window[i - 1];
        err_window[0] = offset;
        wsum = 0;
        foreach (err_window[i])
            wsum += err_window[i];
        drive = longint'(offset) * longint'(kp_model) + longint'(wsum) * longint'(ki_model);
        den   = (scale_model == '0) ? 64'sd1 : longint'(scale_model);
        mag   = (drive < 0) ? -drive : drive;
        disp  = (mag * lsps_pkg::DISP_SCALE) / den;
        if (drive < 0)
            disp = -disp;
        pwm = lsps_pkg::PWM_CENTER - disp;
        if (pwm < 0)
            pwm = 0;
        if (pwm > lsps_pkg::PWM_MAX)
            pwm = lsps_pkg::PWM_MAX;
        if (pwm == 0)
            pinned_low++;
        if (pwm == lsps_pkg::PWM_MAX)
            pinned_high++;
        word.pwm = pwm[lsps_pkg::PWM_W-1:0];
        word.err = offset[lsps_pkg::ERR_W-1:0];
        steer_expect.push_back(word);
    endtask

    task automatic report_mismatch(input string msg);
        // Keep the log short when something breaks wholesale; the count goes on.
        if (fail_count < REPORT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // Input driver: one word from the backlog at a time, random gaps between
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            send_gap  <= 0;
            send_calm <= 0;
        end
        else if (s_tvalid && !s_tready)
        begin
            // hold the word until the core takes it
        end
        else if (send_gap != 0)
        begin
            s_tvalid <= 1'b0;
            send_gap <= send_gap - 1;
        end
        else if (sensor_backlog.size() > 0)
        begin
            s_tvalid <= 1'b1;
            s_tdata  <= {1'b0, sensor_backlog.pop_front()};
            // gap drawn now is spent after this word is accepted
            if (send_calm != 0)
            begin
                send_draw = 0;
                send_calm <= send_calm - 1;
            end
            else
            begin
                send_draw = $urandom_range(0, 18);
                if ($urandom_range(0, 30) == 0)
                    send_calm <= $urandom_range(10, 40);
            end
            send_gap <= send_draw;
        end
        else
        begin
            s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result side back-pressure: a random stall before each word
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            recv_gap  <= 0;
            recv_calm <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            if (recv_calm != 0)
            begin
                recv_draw = 0;
                recv_calm <= recv_calm - 1;
            end
            else
            begin
                recv_draw = $urandom_range(0, 18);
                if ($urandom_range(0, 30) == 0)
                    recv_calm <= $urandom_range(10, 40);
            end
            recv_gap <= recv_draw;
            m_tready <= (recv_draw == 0);
        end
        else if (recv_gap != 0)
        begin
            recv_gap <= recv_gap - 1;
            m_tready <= (recv_gap == 1);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitors: predict on accepted input, check accepted output, track
    // register writes, and watch for a hang
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            words_sent++;
            predict_steering(s_tdata[lsps_pkg::SENSOR_W-1:0]);
        end
    end

    always @(posedge clk)
    begin
        steer_word_t want;
        logic signed [lsps_pkg::ERR_W-1:0] got_err;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_err = $signed(m_tdata[12:8]);
            if (steer_expect.size() == 0)
            begin
                report_mismatch($sformatf("result word %h with nothing outstanding", m_tdata));
            end
            else
            begin
                want = steer_expect.pop_front();
                words_checked++;
                if (m_tdata[7:0] !== want.pwm)
                    report_mismatch($sformatf("pwm_value %0d, want %0d (word %0d)",
                                              m_tdata[7:0], want.pwm, words_checked));
                if (got_err !== want.err)
                    report_mismatch($sformatf("position_error %0d, want %0d (word %0d)",
                                              got_err, want.err, words_checked));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lsps_pkg::CFG_PROP_GAIN:  kp_model    = cfg_data[lsps_pkg::GAIN_W-1:0];
                lsps_pkg::CFG_INTEG_GAIN: ki_model    = cfg_data[lsps_pkg::GAIN_W-1:0];
                lsps_pkg::CFG_FULL_SCALE: scale_model = cfg_data[lsps_pkg::SCALE_W-1:0];
                default: ;   // unmapped index: no register changes
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("no handshake for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, steer_expect.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Holds cfg_valid high across back-to-back writes; caller drops it after.
    task automatic write_register(input logic [lsps_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic load_gains(input logic [lsps_pkg::GAIN_W-1:0] kp,
                              input logic [lsps_pkg::GAIN_W-1:0] ki,
                              input logic [lsps_pkg::SCALE_W-1:0] full_scale);
        write_register(lsps_pkg::CFG_PROP_GAIN, 16'(kp));
        write_register(lsps_pkg::CFG_INTEG_GAIN, 16'(ki));
        write_register(lsps_pkg::CFG_FULL_SCALE, full_scale);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Mix of uniform words and one-sided runs; the runs fill the window so the
    // integral term swings to its limits and drives the clamp.
    task automatic queue_sensor_words(input int count);
        int                            run_len;
        logic                          right_side;
        logic [2:0]                    side_bits;
        logic [lsps_pkg::SENSOR_W-1:0] bits;
        while (count > 0)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                bits = lsps_pkg::SENSOR_W'($urandom_range(0, 127));
                sensor_backlog.push_back(bits);
                count--;
            end
            else
            begin
                run_len    = int'($urandom_range(4, 14));
                right_side = 1'($urandom_range(0, 1));
                while (run_len > 0 && count > 0)
                begin
                    side_bits = 3'($urandom_range(1, 7));
                    bits = right_side ? {3'b000, 1'($urandom_range(0, 1)), side_bits}
                                      : {side_bits, 1'($urandom_range(0, 1)), 3'b000};
                    sensor_backlog.push_back(bits);
                    run_len--;
                    count--;
                end
            end
        end
    endtask

    // Registers may only change with the core idle: every word sent and
    // every result back.
    task automatic drain_core();
        while (sensor_backlog.size() != 0 || s_tvalid || steer_expect.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset gains: silent sensors, each sensor on its
        // own (center alone must read zero), all on, both sides balanced, then
        // a long left run that pins the command high and a right run after it.
        phase_count = 1;
        sensor_backlog.push_back(7'h00);
        sensor_backlog.push_back(7'h40);
        sensor_backlog.push_back(7'h20);
        sensor_backlog.push_back(7'h10);
        sensor_backlog.push_back(7'h08);
        sensor_backlog.push_back(7'h04);
        sensor_backlog.push_back(7'h02);
        sensor_backlog.push_back(7'h01);
        sensor_backlog.push_back(7'h7F);
        sensor_backlog.push_back(7'h77);
        repeat (8) sensor_backlog.push_back(7'h70);
        sensor_backlog.push_back(7'h78);
        repeat (5) sensor_backlog.push_back(7'h07);
        drain_core();

        // Reset gains, random words.
        queue_sensor_words(200);
        drain_core();

        // Largest gains against the smallest full scale: command slams both ways.
        phase_count++;
        load_gains(8'd255, 8'd255, 16'd1);
        sensor_backlog.push_back(7'h07);
        sensor_backlog.push_back(7'h70);
        queue_sensor_words(200);
        drain_core();

        // No gain at all, widest full scale: command must sit at center.
        phase_count++;
        load_gains(8'd0, 8'd0, 16'hFFFF);
        queue_sensor_words(200);
        drain_core();

        // Zero full scale acts as one; also a write to the unmapped index.
        phase_count++;
        load_gains(8'd0, 8'd255, 16'd0);
        write_register(CFG_UNMAPPED, 16'hFFFF);
        cfg_valid <= 1'b0;
        @(posedge clk);
        queue_sensor_words(200);
        drain_core();

        // Proportional only.
        phase_count++;
        load_gains(8'd255, 8'd0, 16'd3000);
        queue_sensor_words(200);
        drain_core();

        // Random settings; full scale mostly small enough to move the command.
        repeat (4)
        begin
            phase_count++;
            load_gains(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                   : 16'($urandom_range(1, 2000)));
            queue_sensor_words(200);
            drain_core();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d sensor words through %0d gain settings, %0d results checked",
                 words_sent, phase_count, words_checked);
        $display("command clamped high %0d times and low %0d times; zero full scale and"
                 , pinned_high, pinned_low);
        $display("  an unmapped register write were exercised");
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
